FILE: hdl/dewd_pkg.sv
// Shared types and constants for the digitizer event word decoder.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package dewd_pkg;

  // Frame layout.
  localparam int HEADER_WORDS    = 13;
  localparam int MAX_FRAME_WORDS = 4096;
  localparam int FIFO_DEPTH      = 4;

  // Header word positions that carry something.
  localparam int POS_IDS      = 0;
  localparam int POS_LED_LOW  = 1;
  localparam int POS_LED_HIGH = 2;
  localparam int POS_PREV_LOW = 3;
  localparam int POS_PREV_HIGH = 4;
  localparam int POS_BASELINE = 5;
  localparam int POS_PRESUM   = 7;
  localparam int POS_POSTSUM  = 8;
  localparam int POS_POST_IDX = 10;
  localparam int POS_PRE_IDX  = 11;
  localparam int POS_PEAK_IDX = 12;

  // Result kinds.
  localparam logic [3:0] KIND_CHAN       = 4'd0;
  localparam logic [3:0] KIND_BOARD      = 4'd1;
  localparam logic [3:0] KIND_ID         = 4'd2;
  localparam logic [3:0] KIND_LED_TS     = 4'd3;
  localparam logic [3:0] KIND_PREV_TS    = 4'd4;
  localparam logic [3:0] KIND_BASELINE   = 4'd5;
  localparam logic [3:0] KIND_PRESUM     = 4'd6;
  localparam logic [3:0] KIND_ENERGY     = 4'd7;
  localparam logic [3:0] KIND_POST_BEGIN = 4'd8;
  localparam logic [3:0] KIND_POST_END   = 4'd9;
  localparam logic [3:0] KIND_PRE_BEGIN  = 4'd10;
  localparam logic [3:0] KIND_PRE_END    = 4'd11;
  localparam logic [3:0] KIND_PEAK       = 4'd12;
  localparam logic [3:0] KIND_BASE       = 4'd13;
  localparam logic [3:0] KIND_TRACE      = 4'd14;
  localparam logic [3:0] KIND_END        = 4'd15;

  // Constant division by reciprocal multiplication: the estimate
  // (y * M) >> DIV_SHIFT is the quotient or one less.
  localparam int          DIV_SHIFT = 26;
  localparam logic [23:0] RECIP_25  = 24'd2684354;   // floor(2^26 / 25)
  localparam logic [23:0] RECIP_5   = 24'd13421772;  // floor(2^26 / 5)
  localparam logic [4:0]  DIVISOR_25 = 5'd25;
  localparam logic [4:0]  DIVISOR_5  = 5'd5;

  // What the back end does with a queued job.
  typedef enum logic [2:0] {
    OP_IDS,   // channel, board and id
    OP_ONE,   // one result, value as queued
    OP_PAIR,  // two 14-bit fields of one word
    OP_DIV,   // one result, queued dividend divided by a constant
    OP_END    // end marker only
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  kind_a;
    logic [3:0]  kind_b;
    logic [47:0] data;
    logic        last;
  } job_t;

endpackage

`default_nettype wire

FILE: hdl/dewd_front.sv
// Front end: byte-swaps each word, tracks its frame position and header state,
// and turns it into a job for the back end. Depends on dewd_pkg.
`default_nettype none

module dewd_front #(
  parameter int MaxFrameWords = dewd_pkg::MAX_FRAME_WORDS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [31:0]      word_i,
  input  wire logic             last_word_i,
  input  wire logic             fifo_full_i,
  output logic                  job_valid_o,
  output dewd_pkg::job_t        job_o
);

  localparam int IdxW = $clog2(MaxFrameWords + 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     led_low_q, led_low_d;
  logic [15:0]     prev_low_q, prev_low_d;
  logic [23:0]     pre_sum_q, pre_sum_d;
  logic [7:0]      post_low_q, post_low_d;

  logic        accept;
  logic [31:0] w;
  logic [11:0] board;
  logic [15:0] id;
  logic [23:0] post;
  logic [23:0] mag;
  logic        produces;
  dewd_pkg::job_t job;

  assign accept = in_valid_i & ~fifo_full_i;
  assign w      = {word_i[7:0], word_i[15:8], word_i[23:16], word_i[31:24]};
  assign board  = w[15:4];
  assign id     = {1'b0, board, 3'b000} + {3'b000, board, 1'b0} + {12'd0, w[3:0]};
  assign post   = {w[15:0], post_low_q};
  assign mag    = (post >= pre_sum_q) ? (post - pre_sum_q) : (pre_sum_q - post);

  always_comb begin
    job        = '0;
    job.op     = dewd_pkg::OP_END;
    job.kind_a = dewd_pkg::KIND_END;
    job.kind_b = dewd_pkg::KIND_END;
    job.last   = last_word_i;
    produces   = 1'b1;
    led_low_d  = led_low_q;
    prev_low_d = prev_low_q;
    pre_sum_d  = pre_sum_q;
    post_low_d = post_low_q;

    if (idx_q == IdxW'(MaxFrameWords)) begin
      produces = 1'b0;
    end else if (idx_q >= IdxW'(dewd_pkg::HEADER_WORDS)) begin
      job.op     = dewd_pkg::OP_PAIR;
      job.kind_a = dewd_pkg::KIND_TRACE;
      job.kind_b = dewd_pkg::KIND_TRACE;
      job.data   = {16'd0, w};
    end else begin
      unique case (idx_q)
        IdxW'(dewd_pkg::POS_IDS): begin
          job.op   = dewd_pkg::OP_IDS;
          job.data = {16'd0, id, w[15:0]};
        end
        IdxW'(dewd_pkg::POS_LED_LOW): begin
          led_low_d = w;
          produces  = 1'b0;
        end
        IdxW'(dewd_pkg::POS_LED_HIGH): begin
          job.op     = dewd_pkg::OP_ONE;
          job.kind_a = dewd_pkg::KIND_LED_TS;
          job.data   = {w[15:0], led_low_q};
        end
        IdxW'(dewd_pkg::POS_PREV_LOW): begin
          prev_low_d = w[15:0];
          produces   = 1'b0;
        end
        IdxW'(dewd_pkg::POS_PREV_HIGH): begin
          job.op     = dewd_pkg::OP_ONE;
          job.kind_a = dewd_pkg::KIND_PREV_TS;
          job.data   = {w, prev_low_q};
        end
        IdxW'(dewd_pkg::POS_BASELINE): begin
          job.op     = dewd_pkg::OP_ONE;
          job.kind_a = dewd_pkg::KIND_BASELINE;
          job.data   = {24'd0, w[23:0]};
        end
        IdxW'(dewd_pkg::POS_PRESUM): begin
          // The sum divided by 400 is the sum over 16, divided by 25.
          pre_sum_d  = w[23:0];
          post_low_d = w[31:24];
          job.op     = dewd_pkg::OP_DIV;
          job.kind_a = dewd_pkg::KIND_PRESUM;
          job.data   = {28'd0, w[23:4]};
        end
        IdxW'(dewd_pkg::POS_POSTSUM): begin
          // The magnitude divided by 10 is the magnitude over 2, divided by 5.
          job.op     = dewd_pkg::OP_DIV;
          job.kind_a = dewd_pkg::KIND_ENERGY;
          job.data   = {25'd0, mag[23:1]};
        end
        IdxW'(dewd_pkg::POS_POST_IDX): begin
          job.op     = dewd_pkg::OP_PAIR;
          job.kind_a = dewd_pkg::KIND_POST_BEGIN;
          job.kind_b = dewd_pkg::KIND_POST_END;
          job.data   = {16'd0, w};
        end
        IdxW'(dewd_pkg::POS_PRE_IDX): begin
          job.op     = dewd_pkg::OP_PAIR;
          job.kind_a = dewd_pkg::KIND_PRE_BEGIN;
          job.kind_b = dewd_pkg::KIND_PRE_END;
          job.data   = {16'd0, w};
        end
        IdxW'(dewd_pkg::POS_PEAK_IDX): begin
          job.op     = dewd_pkg::OP_PAIR;
          job.kind_a = dewd_pkg::KIND_PEAK;
          job.kind_b = dewd_pkg::KIND_BASE;
          job.data   = {16'd0, w};
        end
        default: begin
          produces = 1'b0;
        end
      endcase
    end

    if (last_word_i) begin
      idx_d = '0;
    end else if (idx_q != IdxW'(MaxFrameWords)) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = idx_q;
    end
  end

  // A silent word still queues the end marker when it closes the frame.
  assign job_valid_o = accept & (produces | last_word_i);
  assign job_o       = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      led_low_q  <= '0;
      prev_low_q <= '0;
      pre_sum_q  <= '0;
      post_low_q <= '0;
    end else if (accept) begin
      idx_q      <= idx_d;
      led_low_q  <= led_low_d;
      prev_low_q <= prev_low_d;
      pre_sum_q  <= pre_sum_d;
      post_low_q <= post_low_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(MaxFrameWords))
    else $error("frame position beyond saturation");
`endif

endmodule

`default_nettype wire

FILE: hdl/dewd_fifo.sv
// Short job queue between the front and back ends.
// Depends on dewd_pkg for the job type.
`default_nettype none

module dewd_fifo #(
  parameter int Depth = dewd_pkg::FIFO_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  dewd_pkg::job_t      wr_data_i,
  output logic                full_o,
  input  wire logic           rd_en_i,
  output dewd_pkg::job_t      rd_data_o,
  output logic                empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dewd_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && full_o) |-> 1'b0)
    else $error("job written into a full queue");
`endif

endmodule

`default_nettype wire

FILE: hdl/dewd_back.sv
// Back end: takes jobs from the queue and delivers their results one per
// cycle into the output register while it is free or being popped,
// dividing by constants where needed. Depends on dewd_pkg.
`default_nettype none

module dewd_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         fifo_empty_i,
  input  dewd_pkg::job_t    fifo_data_i,
  output logic              fifo_rd_o,
  output logic              empty_o,
  input  wire logic         pop_i,
  output logic [3:0]        kind_o,
  output logic [47:0]       value_o,
  output logic              frame_end_o
);

  dewd_pkg::job_t job_q;
  logic           job_valid_q;
  logic [1:0]     cnt_q;
  logic [20:0]    qest_q;

  logic           out_valid_q;
  logic [3:0]     kind_q;
  logic [47:0]    value_q;
  logic           frame_end_q;

  logic           out_ready;
  logic           emit;
  logic           final_res;
  logic           load;
  logic [1:0]     n_res;
  logic [23:0]    recip;
  logic [46:0]    prod;
  logic [4:0]     divisor;
  logic [25:0]    rem;
  logic [20:0]    quot;
  logic [3:0]     res_kind;
  logic [47:0]    res_value;

  assign out_ready = ~out_valid_q | pop_i;
  assign emit      = job_valid_q & out_ready;

  always_comb begin
    unique case (job_q.op)
      dewd_pkg::OP_IDS:  n_res = 2'd3;
      dewd_pkg::OP_PAIR: n_res = 2'd2;
      default:           n_res = 2'd1;
    endcase
  end

  assign final_res = (cnt_q == n_res - 2'd1);
  assign load      = ~fifo_empty_i & (~job_valid_q | (emit & final_res));
  assign fifo_rd_o = load;

  // Reciprocal product for the job being loaded, registered with it.
  assign recip = (fifo_data_i.kind_a == dewd_pkg::KIND_PRESUM) ?
                 dewd_pkg::RECIP_25 : dewd_pkg::RECIP_5;
  assign prod  = fifo_data_i.data[22:0] * recip;

  // The estimate is at most one short; one compare settles it.
  assign divisor = (job_q.kind_a == dewd_pkg::KIND_PRESUM) ?
                   dewd_pkg::DIVISOR_25 : dewd_pkg::DIVISOR_5;
  assign rem     = {3'd0, job_q.data[22:0]} - (26'(qest_q) * 26'(divisor));
  assign quot    = (rem >= 26'(divisor)) ? qest_q + 21'd1 : qest_q;

  always_comb begin
    res_kind  = job_q.kind_a;
    res_value = job_q.data;
    unique case (job_q.op)
      dewd_pkg::OP_IDS: begin
        unique case (cnt_q)
          2'd0: begin
            res_kind  = dewd_pkg::KIND_CHAN;
            res_value = {44'd0, job_q.data[3:0]};
          end
          2'd1: begin
            res_kind  = dewd_pkg::KIND_BOARD;
            res_value = {36'd0, job_q.data[15:4]};
          end
          default: begin
            res_kind  = dewd_pkg::KIND_ID;
            res_value = {32'd0, job_q.data[31:16]};
          end
        endcase
      end
      dewd_pkg::OP_PAIR: begin
        if (cnt_q == 2'd0) begin
          res_kind  = job_q.kind_a;
          res_value = {34'd0, job_q.data[13:0]};
        end else begin
          res_kind  = job_q.kind_b;
          res_value = {34'd0, job_q.data[29:16]};
        end
      end
      dewd_pkg::OP_DIV: begin
        res_value = {27'd0, quot};
      end
      dewd_pkg::OP_END: begin
        res_kind  = dewd_pkg::KIND_END;
        res_value = '0;
      end
      default: begin
        res_value = job_q.data;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q  <= fifo_data_i;
      qest_q <= prod[46:dewd_pkg::DIV_SHIFT];
    end
    if (emit) begin
      kind_q      <= res_kind;
      value_q     <= res_value;
      frame_end_q <= job_q.last & final_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        job_valid_q <= 1'b1;
        cnt_q       <= '0;
      end else if (emit) begin
        if (final_res) begin
          job_valid_q <= 1'b0;
          cnt_q       <= '0;
        end else begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o     = ~out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign frame_end_o = frame_end_q;

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (cnt_q < n_res))
    else $error("result counter beyond the job's result count");

  a_end_marks_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == dewd_pkg::KIND_END) |-> frame_end_q)
    else $error("end marker without frame end");

  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && job_q.op == dewd_pkg::OP_DIV) |-> (rem < 26'(2 * divisor)))
    else $error("reciprocal estimate off by more than one");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!job_valid_q || emit))
    else $error("job overwritten before all its results were delivered");
`endif

endmodule

`default_nettype wire

FILE: hdl/digitizer_event_word_decoder_unit.sv
// Top level of the digitizer event word decoder: front end, job queue and
// back end. Depends on dewd_pkg, dewd_front, dewd_fifo and dewd_back.
//
// Usage. Frame words enter on word_i with last_word_i marking the final word;
// a word is taken at a clock edge with push high and full low. Results leave
// through kind_o, value_o and frame_end_o while empty is low and are taken at
// an edge with pop high. Each header word gives zero to three results, each
// trace word two, and a silent word that closes a frame gives an end marker.
// The first result of a word passes through the queue, the job register and
// the output register on its way to the ports. Throughput: the back end
// delivers one result per cycle while the output register is free or popped;
// the queue lets several words be taken while earlier results are still
// being delivered. Reset empties the queue and the output register and
// returns the frame position to zero. While the receiver holds pop low
// the result on the ports stays, the queue fills and then full is raised.
`default_nettype none

module digitizer_event_word_decoder_unit #(
  parameter int MaxFrameWords = dewd_pkg::MAX_FRAME_WORDS,
  parameter int FifoDepth     = dewd_pkg::FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] word_i,
  input  wire logic        last_word_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       kind_o,
  output logic [47:0]      value_o,
  output logic             frame_end_o
);

  logic           job_valid;
  dewd_pkg::job_t job_in;
  dewd_pkg::job_t job_out;
  logic           fifo_full;
  logic           fifo_empty;
  logic           fifo_rd;

  dewd_front #(
    .MaxFrameWords(MaxFrameWords)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .word_i     (word_i),
    .last_word_i(last_word_i),
    .fifo_full_i(fifo_full),
    .job_valid_o(job_valid),
    .job_o      (job_in)
  );

  dewd_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_valid),
    .wr_data_i(job_in),
    .full_o   (fifo_full),
    .rd_en_i  (fifo_rd),
    .rd_data_o(job_out),
    .empty_o  (fifo_empty)
  );

  dewd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_empty_i(fifo_empty),
    .fifo_data_i (job_out),
    .fifo_rd_o   (fifo_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .frame_end_o (frame_end_o)
  );

  assign full = fifo_full;

endmodule

`default_nettype wire
